[src/ray_sphere_nearest_hit_top_defines.svh]
// Assertion macros shared by the checking code of the ray/sphere block.
`ifndef RAY_SPHERE_NEAREST_HIT_TOP_DEFINES_SVH
`define RAY_SPHERE_NEAREST_HIT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSNH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsnh same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSNH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rsnh next-cycle check failed");

`endif

[src/rsnh_pkg.sv]
package rsnh_pkg;

   localparam int MAX_SPHERES = 16;
   localparam int SLOT_W      = $clog2(MAX_SPHERES);
   localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
   localparam int FRAC_BITS   = 16;
   localparam int WORD_W      = 32;
   localparam int PROD_W      = 2 * WORD_W;
   localparam int FM_W        = PROD_W - FRAC_BITS;
   localparam int ACC_W       = FM_W + 2;
   localparam int DIFF_W      = ACC_W + 1;
   localparam int T_W         = WORD_W + 1;
   localparam int DIST_W      = 31;
   localparam int RAD_W       = 31;
   localparam int NORM_W      = 18;
   localparam int MAT_W       = 8;
   localparam int SQ_IN_W     = PROD_W;
   localparam int SQ_OUT_W    = SQ_IN_W / 2;
   localparam int DIV_N_W     = WORD_W + FRAC_BITS;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DIST_W-1:0] DIST_MAX        = '1;
   localparam logic [DIST_W-1:0] HIT_LIMIT_RESET = 31'd65536000;
   localparam logic [NORM_W-1:0] NORM_ONE        = NORM_W'(1) << FRAC_BITS;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RAY  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPHERE_COUNT = 1'b0,
      CSR_HIT_LIMIT    = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LSUB,
      ST_MUL,
      ST_MUL_END,
      ST_EVAL,
      ST_SQRT,
      ST_NEXT,
      ST_FINISH,
      ST_HREAD,
      ST_HMUL,
      ST_HSQ,
      ST_HSQ_WAIT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] cx;
      logic signed [WORD_W-1:0] cy;
      logic signed [WORD_W-1:0] cz;
      logic [RAD_W-1:0]         radius;
      logic [MAT_W-1:0]         material;
   } sphere_type;

   localparam logic signed [PROD_W-1:0] S32_MAX_W = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] S32_MIN_W = -64'sd2147483648;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > S32_MAX_W) begin
         return S32_MAX_W[WORD_W-1:0];
      end
      if (v < S32_MIN_W) begin
         return S32_MIN_W[WORD_W-1:0];
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

[src/rsnh_req_if.sv]
interface rsnh_req_if;
   import rsnh_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [SLOT_W-1:0]        slot;
   logic signed [WORD_W-1:0] point_x;
   logic signed [WORD_W-1:0] point_y;
   logic signed [WORD_W-1:0] point_z;
   logic signed [WORD_W-1:0] dir_x;
   logic signed [WORD_W-1:0] dir_y;
   logic signed [WORD_W-1:0] dir_z;
   logic [RAD_W-1:0]         radius;
   logic [MAT_W-1:0]         material_tag;

   modport source (output valid, kind, slot, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                   radius, material_tag, input ready);
   modport sink (input valid, kind, slot, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                 radius, material_tag, output ready);
endinterface

interface rsnh_rsp_if;
   import rsnh_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [DIST_W-1:0]        distance;
   logic signed [WORD_W-1:0] hit_x;
   logic signed [WORD_W-1:0] hit_y;
   logic signed [WORD_W-1:0] hit_z;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic signed [NORM_W-1:0] normal_z;
   logic [MAT_W-1:0]         material_out;

   modport source (output valid, hit, distance, hit_x, hit_y, hit_z, normal_x, normal_y,
                   normal_z, material_out, input ready);
   modport sink (input valid, hit, distance, hit_x, hit_y, hit_z, normal_x, normal_y,
                 normal_z, material_out, output ready);
endinterface

interface rsnh_csr_if;
   import rsnh_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/rsnh_table.sv]
module rsnh_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [rsnh_pkg::SLOT_W-1:0] wr_addr,
   input  rsnh_pkg::sphere_type       wr_data,
   input  logic [rsnh_pkg::SLOT_W-1:0] rd_addr,
   output rsnh_pkg::sphere_type       rd_data
);
   import rsnh_pkg::*;

   sphere_type mem [MAX_SPHERES];
   sphere_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rsnh_sqrt.sv]
module rsnh_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsnh_pkg::SQ_IN_W-1:0]  operand,
   output logic                          done,
   output logic [rsnh_pkg::SQ_OUT_W-1:0] root
);
   import rsnh_pkg::*;

   localparam int STEP_W = $clog2(SQ_OUT_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_IN_W-1:0] v_ff, v_in;
   logic [SQ_IN_W-1:0] res_ff, res_in;
   logic [SQ_IN_W-1:0] bit_ff, bit_in;
   logic [SQ_IN_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   // One result bit per cycle, the classic digit-by-digit square root.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         v_in    = operand;
         res_in  = '0;
         bit_in  = SQ_IN_W'(1) << (SQ_IN_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[SQ_OUT_W-1:0];

endmodule

[src/rsnh_div.sv]
module rsnh_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rsnh_pkg::DIV_N_W-1:0] dividend,
   input  logic [rsnh_pkg::WORD_W-1:0]  divisor,
   output logic                         done,
   output logic [rsnh_pkg::DIV_N_W-1:0] quotient
);
   import rsnh_pkg::*;

   localparam int STEP_W = $clog2(DIV_N_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0]  rem_ff, rem_in;
   logic [DIV_N_W-1:0] q_ff, q_in;
   logic [WORD_W-1:0]  dsr_ff, dsr_in;
   logic [WORD_W:0]    shifted;
   logic [WORD_W:0]    diff;

   assign shifted = {rem_ff, q_ff[DIV_N_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(DIV_N_W - 1);
         rem_in  = '0;
         q_in    = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            q_in   = {q_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            q_in   = {q_ff[DIV_N_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[src/ray_sphere_nearest_hit_top.sv]
// Nearest ray/sphere hit over a sixteen-slot sphere table, with coordinates and directions
// in signed Q16.16 and normal components in signed Q1.16. A load word (kind 0) writes
// center, radius and material into one slot as it is taken and gives no result. A ray
// word (kind 1) tests slots 0 to min(sphere_count, 16)-1 with the geometric method and
// returns exactly one result word: hit flag, distance (saturated, all ones on a miss),
// hit point, unit normal and material; on a miss or a hit at or beyond hit_limit the
// geometry and material are zero. The block takes one word at a time and, after a ray
// word, drops req ready until the result word has been taken. A sphere that fails the
// reject tests skips the square root, and the hit point and normal are worked out only
// for a hit. The work runs on one shared 32x32 multiplier (eight products per sphere,
// six for the hit point and normal), a square-root unit that settles one root bit per
// cycle and a divider that settles one quotient bit per cycle, run once for each of the
// three normal components when the normal length is not zero.
// Registers are to be written through the csr port only while no ray is in flight; the
// block itself does not enforce this.
module ray_sphere_nearest_hit_top (
   input logic      clock,
   input logic      reset,
   rsnh_req_if.sink   req_bus,
   rsnh_rsp_if.source rsp_bus,
   rsnh_csr_if.sink   csr_bus
);
   import rsnh_pkg::*;

   // Control state and configuration.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [2:0]        step_ff, step_in;
   logic [1:0]        comp_ff, comp_in;
   logic              best_valid_ff, best_valid_in;
   logic [CNT_W-1:0]  sphere_count_ff, sphere_count_in;
   logic [DIST_W-1:0] hit_limit_ff, hit_limit_in;

   // Datapath registers.
   logic signed [WORD_W-1:0] o_ff [3];
   logic signed [WORD_W-1:0] o_in [3];
   logic signed [WORD_W-1:0] d_ff [3];
   logic signed [WORD_W-1:0] d_in [3];
   logic signed [WORD_W-1:0] l_ff [3];
   logic signed [WORD_W-1:0] l_in [3];
   logic signed [WORD_W-1:0] p_ff [3];
   logic signed [WORD_W-1:0] p_in [3];
   logic signed [WORD_W-1:0] n_ff [3];
   logic signed [WORD_W-1:0] n_in [3];
   logic signed [NORM_W-1:0] norm_ff [3];
   logic signed [NORM_W-1:0] norm_in [3];
   logic signed [WORD_W-1:0] rad_ff, rad_in;
   logic signed [WORD_W-1:0] tca_ff, tca_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  tca_acc_ff, tca_acc_in;
   logic signed [ACC_W-1:0]  ll_acc_ff, ll_acc_in;
   logic signed [FM_W-1:0]   tca2_ff, tca2_in;
   logic signed [FM_W-1:0]   r2_ff, r2_in;
   logic [T_W-1:0]           best_t_ff, best_t_in;
   logic [SLOT_W-1:0]        best_idx_ff, best_idx_in;
   logic [PROD_W-1:0]        ss_ff, ss_in;
   logic [WORD_W-1:0]        len_ff, len_in;
   logic                     out_hit_ff, out_hit_in;
   logic [DIST_W-1:0]        out_dist_ff, out_dist_in;
   logic [MAT_W-1:0]         out_mat_ff, out_mat_in;

   // Combinational helpers.
   logic                     req_fire;
   logic                     hit_phase;
   logic [SLOT_W-1:0]        rd_addr;
   sphere_type               wr_data;
   sphere_type               rd_data;
   logic [1:0]               lane;
   logic signed [WORD_W-1:0] c_sel;
   logic signed [WORD_W-1:0] n_sel;
   logic signed [WORD_W-1:0] mul_a, mul_b;
   logic signed [FM_W-1:0]   fm;
   logic signed [DIFF_W-1:0] d2, r2_ext, r2_md;
   logic                     reject;
   logic [SQ_IN_W-1:0]       sq_x;
   logic                     sq_start, sq_done;
   logic [SQ_IN_W-1:0]       sq_op;
   logic [SQ_OUT_W-1:0]      sq_root;
   logic signed [T_W:0]      t_lo, t_hi;
   logic [T_W-1:0]           t_val;
   logic [CNT_W-1:0]         count_eff;
   logic [DIST_W-1:0]        dist_val;
   logic                     hit_val;
   logic                     div_start, div_done;
   logic [WORD_W-1:0]        n_abs;
   logic [DIV_N_W-1:0]       div_q;
   logic [NORM_W-1:0]        q_clamp;
   logic signed [WORD_W-1:0] n_cur;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign hit_phase = (state_ff == ST_HREAD) || (state_ff == ST_HMUL) ||
                      (state_ff == ST_HSQ) || (state_ff == ST_HSQ_WAIT) ||
                      (state_ff == ST_DIV_START) || (state_ff == ST_DIV_WAIT) ||
                      (state_ff == ST_FINISH);
   assign rd_addr   = hit_phase ? best_idx_ff : idx_ff[SLOT_W-1:0];

   assign wr_data.cx       = req_bus.point_x;
   assign wr_data.cy       = req_bus.point_y;
   assign wr_data.cz       = req_bus.point_z;
   assign wr_data.radius   = req_bus.radius;
   assign wr_data.material = req_bus.material_tag;

   rsnh_table u_table (
      .clock   (clock),
      .wr_en   (req_fire && (req_bus.kind == KIND_LOAD)),
      .wr_addr (req_bus.slot),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsnh_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_op),
      .done    (sq_done),
      .root    (sq_root)
   );

   rsnh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({n_abs, {FRAC_BITS{1'b0}}}),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // The multiplier steps walk the three axes twice, so one lane select serves both passes.
   always_comb begin
      case (step_ff)
         3'd0, 3'd3: lane = 2'd0;
         3'd1, 3'd4: lane = 2'd1;
         3'd2, 3'd5: lane = 2'd2;
         default:    lane = 2'd0;
      endcase
   end

   always_comb begin
      case (lane)
         2'd0:    c_sel = rd_data.cx;
         2'd1:    c_sel = rd_data.cy;
         default: c_sel = rd_data.cz;
      endcase
   end

   // Surface offset of the hit point from the sphere center, one axis at a time.
   assign n_sel = sat32(PROD_W'(p_ff[lane]) - PROD_W'(c_sel));

   // Operand select for the shared multiplier. Its product is registered every cycle,
   // and the step after an issue consumes it.
   always_comb begin
      mul_a = l_ff[lane];
      mul_b = d_ff[lane];
      case (state_ff)
         ST_MUL: begin
            if (step_ff < 3'd3) begin
               mul_a = l_ff[lane];
               mul_b = d_ff[lane];
            end else if (step_ff < 3'd6) begin
               mul_a = l_ff[lane];
               mul_b = l_ff[lane];
            end else if (step_ff == 3'd6) begin
               mul_a = tca_ff;
               mul_b = tca_ff;
            end else begin
               mul_a = rad_ff;
               mul_b = rad_ff;
            end
         end
         ST_HMUL: begin
            if (step_ff < 3'd3) begin
               mul_a = d_ff[lane];
               mul_b = $signed({1'b0, best_t_ff[WORD_W-2:0]});
            end else begin
               mul_a = n_sel;
               mul_b = n_sel;
            end
         end
         default: begin
            mul_a = l_ff[lane];
            mul_b = d_ff[lane];
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign fm      = FM_W'(prod_ff >>> FRAC_BITS);

   // Reject tests and the square-root argument for one sphere.
   assign d2     = DIFF_W'(ll_acc_ff) - DIFF_W'(tca2_ff);
   assign r2_ext = DIFF_W'(r2_ff);
   assign reject = tca_ff[WORD_W-1] || (d2 > r2_ext);
   assign r2_md  = r2_ext - d2;
   assign sq_x   = {r2_md[SQ_IN_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

   assign sq_start = ((state_ff == ST_EVAL) && !reject) || (state_ff == ST_HSQ);
   assign sq_op    = (state_ff == ST_EVAL) ? sq_x : ss_ff;

   // Take the near root unless it lies behind the origin.
   assign t_lo  = (T_W + 1)'(tca_ff) - $signed({2'b00, sq_root});
   assign t_hi  = (T_W + 1)'(tca_ff) + $signed({2'b00, sq_root});
   assign t_val = t_lo[T_W] ? t_hi[T_W-1:0] : t_lo[T_W-1:0];

   assign count_eff = (sphere_count_ff > CNT_W'(MAX_SPHERES)) ? CNT_W'(MAX_SPHERES)
                                                               : sphere_count_ff;

   assign dist_val = (!best_valid_ff || (best_t_ff > T_W'(DIST_MAX))) ? DIST_MAX
                                                                     : best_t_ff[DIST_W-1:0];
   assign hit_val  = best_valid_ff && (dist_val < hit_limit_ff);

   // Normal component: |n| scaled by one, divided by the length, clamped to one.
   assign n_cur     = n_ff[comp_ff];
   assign n_abs     = n_cur[WORD_W-1] ? WORD_W'(-n_cur) : n_cur;
   assign div_start = (state_ff == ST_DIV_START) && (len_ff != '0);
   assign q_clamp   = (div_q > DIV_N_W'(NORM_ONE)) ? NORM_ONE : div_q[NORM_W-1:0];

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      comp_in         = comp_ff;
      best_valid_in   = best_valid_ff;
      sphere_count_in = sphere_count_ff;
      hit_limit_in    = hit_limit_ff;
      o_in            = o_ff;
      d_in            = d_ff;
      l_in            = l_ff;
      p_in            = p_ff;
      n_in            = n_ff;
      norm_in         = norm_ff;
      rad_in          = rad_ff;
      tca_in          = tca_ff;
      tca_acc_in      = tca_acc_ff;
      ll_acc_in       = ll_acc_ff;
      tca2_in         = tca2_ff;
      r2_in           = r2_ff;
      best_t_in       = best_t_ff;
      best_idx_in     = best_idx_ff;
      ss_in           = ss_ff;
      len_in          = len_ff;
      out_hit_in      = out_hit_ff;
      out_dist_in     = out_dist_ff;
      out_mat_in      = out_mat_ff;

      if (csr_bus.valid) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_SPHERE_COUNT: sphere_count_in = csr_bus.data[CNT_W-1:0];
            CSR_HIT_LIMIT:    hit_limit_in = csr_bus.data[DIST_W-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.kind == KIND_RAY)) begin
               o_in[0]       = req_bus.point_x;
               o_in[1]       = req_bus.point_y;
               o_in[2]       = req_bus.point_z;
               d_in[0]       = req_bus.dir_x;
               d_in[1]       = req_bus.dir_y;
               d_in[2]       = req_bus.dir_z;
               count_in      = count_eff;
               idx_in        = '0;
               best_valid_in = 1'b0;
               state_in      = (count_eff == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LSUB;
         end
         ST_LSUB: begin
            l_in[0]    = sat32(PROD_W'(rd_data.cx) - PROD_W'(o_ff[0]));
            l_in[1]    = sat32(PROD_W'(rd_data.cy) - PROD_W'(o_ff[1]));
            l_in[2]    = sat32(PROD_W'(rd_data.cz) - PROD_W'(o_ff[2]));
            rad_in     = $signed({1'b0, rd_data.radius});
            tca_acc_in = '0;
            ll_acc_in  = '0;
            step_in    = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            // Products issued at steps 0-2 are L.D, 3-5 are L.L, 6 is tca^2, 7 is r^2.
            if ((step_ff >= 3'd1) && (step_ff <= 3'd3)) begin
               tca_acc_in = tca_acc_ff + ACC_W'(fm);
            end
            if ((step_ff >= 3'd4) && (step_ff <= 3'd6)) begin
               ll_acc_in = ll_acc_ff + ACC_W'(fm);
            end
            if (step_ff == 3'd4) begin
               tca_in = sat32(PROD_W'(tca_acc_ff));
            end
            if (step_ff == 3'd7) begin
               tca2_in  = fm;
               state_in = ST_MUL_END;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_MUL_END: begin
            r2_in    = fm;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = reject ? ST_NEXT : ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_done) begin
               // Strictly nearer only, so the lowest slot wins a tie.
               if (!best_valid_ff || (t_val < best_t_ff)) begin
                  best_valid_in = 1'b1;
                  best_t_in     = t_val;
                  best_idx_in   = idx_ff[SLOT_W-1:0];
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ((idx_ff + 1'b1) == count_ff) ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            out_hit_in  = hit_val;
            out_dist_in = dist_val;
            ss_in       = '0;
            step_in     = '0;
            if (hit_val) begin
               state_in = ST_HREAD;
            end else begin
               p_in[0]    = '0;
               p_in[1]    = '0;
               p_in[2]    = '0;
               norm_in[0] = '0;
               norm_in[1] = '0;
               norm_in[2] = '0;
               out_mat_in = '0;
               state_in   = ST_OUT;
            end
         end
         ST_HREAD: begin
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            // Steps 0-2 issue D*t, steps 3-5 issue n^2; each product is consumed by the step after its issue.
            out_mat_in = rd_data.material;
            if ((step_ff >= 3'd1) && (step_ff <= 3'd3)) begin
               case (step_ff)
                  3'd1:    p_in[0] = sat32(PROD_W'(o_ff[0]) + PROD_W'(fm));
                  3'd2:    p_in[1] = sat32(PROD_W'(o_ff[1]) + PROD_W'(fm));
                  default: p_in[2] = sat32(PROD_W'(o_ff[2]) + PROD_W'(fm));
               endcase
            end
            if ((step_ff >= 3'd3) && (step_ff <= 3'd5)) begin
               n_in[lane] = n_sel;
            end
            if (step_ff >= 3'd4) begin
               ss_in = ss_ff + $unsigned(prod_ff);
            end
            if (step_ff == 3'd6) begin
               state_in = ST_HSQ;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_HSQ: begin
            state_in = ST_HSQ_WAIT;
         end
         ST_HSQ_WAIT: begin
            if (sq_done) begin
               len_in   = sq_root;
               comp_in  = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (len_ff == '0) begin
               norm_in[comp_ff] = '0;
               if (comp_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               norm_in[comp_ff] = n_cur[WORD_W-1] ? NORM_W'(-$signed(q_clamp))
                                                  : $signed(q_clamp);
               if (comp_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         best_valid_ff   <= 1'b0;
         sphere_count_ff <= '0;
         hit_limit_ff    <= HIT_LIMIT_RESET;
      end else begin
         state_ff        <= state_in;
         best_valid_ff   <= best_valid_in;
         sphere_count_ff <= sphere_count_in;
         hit_limit_ff    <= hit_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      comp_ff     <= comp_in;
      o_ff        <= o_in;
      d_ff        <= d_in;
      l_ff        <= l_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      norm_ff     <= norm_in;
      rad_ff      <= rad_in;
      tca_ff      <= tca_in;
      prod_ff     <= prod_in;
      tca_acc_ff  <= tca_acc_in;
      ll_acc_ff   <= ll_acc_in;
      tca2_ff     <= tca2_in;
      r2_ff       <= r2_in;
      best_t_ff   <= best_t_in;
      best_idx_ff <= best_idx_in;
      ss_ff       <= ss_in;
      len_ff      <= len_in;
      out_hit_ff  <= out_hit_in;
      out_dist_ff <= out_dist_in;
      out_mat_ff  <= out_mat_in;
   end

   // Input side is open only between rays; configuration writes are always taken.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = (state_ff == ST_OUT);
   assign rsp_bus.hit          = out_hit_ff;
   assign rsp_bus.distance     = out_dist_ff;
   assign rsp_bus.hit_x        = p_ff[0];
   assign rsp_bus.hit_y        = p_ff[1];
   assign rsp_bus.hit_z        = p_ff[2];
   assign rsp_bus.normal_x     = norm_ff[0];
   assign rsp_bus.normal_y     = norm_ff[1];
   assign rsp_bus.normal_z     = norm_ff[2];
   assign rsp_bus.material_out = out_mat_ff;

`include "ray_sphere_nearest_hit_top_defines.svh"

   `RSNH_ASSERT_NOW(a_rsp_holds_req, rsp_bus.valid, !req_bus.ready)
   `RSNH_ASSERT_NOW(a_hit_within_limit, rsp_bus.valid && rsp_bus.hit, rsp_bus.distance < hit_limit_ff)
   `RSNH_ASSERT_NOW(a_miss_is_clear, rsp_bus.valid && !rsp_bus.hit, rsp_bus.hit_x == '0 && rsp_bus.normal_x == '0 && rsp_bus.material_out == '0)
   `RSNH_ASSERT_NEXT(a_ray_goes_busy, req_bus.valid && req_bus.ready && req_bus.kind == KIND_RAY, !req_bus.ready)

endmodule

[test/rsnh_checker.sv]
`timescale 1ns / 1ps

// Watches the request, response and csr channels, keeps a private copy of the sphere table
// and the registers, and checks each response word against the predicted nearest hit.
module rsnh_checker (
   input  logic  clock,
   input  logic  reset,
   rsnh_req_if   req_bus,
   rsnh_rsp_if   rsp_bus,
   rsnh_csr_if   csr_bus,
   output int    fail_count,
   output int    words_pending
);
   import rsnh_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic [DIST_W-1:0]        distance;
      logic signed [WORD_W-1:0] hit_x;
      logic signed [WORD_W-1:0] hit_y;
      logic signed [WORD_W-1:0] hit_z;
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic [MAT_W-1:0]         material;
   } hit_word_type;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint ONE_Q    = 64'sd1 << FRAC_BITS;

   longint       center_tab [3][MAX_SPHERES];
   longint       radius_tab [MAX_SPHERES];
   logic [7:0]   mat_tab [MAX_SPHERES];
   int           spheres_tested;
   longint       dist_limit;
   hit_word_type hit_words [$];

   function automatic longint clamp32(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // Fixed-point product, floored.
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unit_comp(longint n, logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      if (len == 0) return 0;
      mag = 64'(n < 0 ? -n : n) << FRAC_BITS;
      q = mag / len;
      if (q > 64'(ONE_Q)) q = 64'(ONE_Q);
      return n < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic hit_word_type nearest_hit(longint o[3], longint d[3]);
      hit_word_type w;
      int           best;
      int           n_test;
      longint       best_t, tca, ll, d2, r2, t, thc, l, near_dist;
      longint       p[3], nv[3], comp[3];
      logic [63:0]  ss, len;
      best = -1;
      best_t = 0;
      n_test = spheres_tested > MAX_SPHERES ? MAX_SPHERES : spheres_tested;
      for (int i = 0; i < n_test; i++) begin
         tca = 0;
         ll = 0;
         for (int k = 0; k < 3; k++) begin
            l = clamp32(center_tab[k][i] - o[k]);
            tca += qmul(l, d[k]);
            ll += qmul(l, l);
         end
         tca = clamp32(tca);
         if (tca < 0) continue;
         d2 = ll - qmul(tca, tca);
         r2 = qmul(radius_tab[i], radius_tab[i]);
         if (d2 > r2) continue;
         thc = longint'(root64(64'(r2 - d2) << FRAC_BITS));
         t = tca - thc;
         if (t < 0) t = tca + thc;
         if (best < 0 || t < best_t) begin
            best = i;
            best_t = t;
         end
      end
      near_dist = (best < 0 || best_t > WORD_MAX) ? WORD_MAX : best_t;
      w = '0;
      w.distance = near_dist[DIST_W-1:0];
      w.hit = best >= 0 && near_dist < dist_limit;
      if (w.hit) begin
         ss = 0;
         for (int k = 0; k < 3; k++) begin
            p[k] = clamp32(o[k] + qmul(d[k], best_t));
            nv[k] = clamp32(p[k] - center_tab[k][best]);
            ss = ss + 64'(nv[k] * nv[k]);
         end
         len = root64(ss);
         for (int k = 0; k < 3; k++) comp[k] = unit_comp(nv[k], len);
         w.hit_x = p[0][WORD_W-1:0];
         w.hit_y = p[1][WORD_W-1:0];
         w.hit_z = p[2][WORD_W-1:0];
         w.normal_x = comp[0][NORM_W-1:0];
         w.normal_y = comp[1][NORM_W-1:0];
         w.normal_z = comp[2][NORM_W-1:0];
         w.material = mat_tab[best];
      end
      return w;
   endfunction

   always @(posedge clock) begin
      longint       o[3], d[3];
      hit_word_type got, want;
      if (reset) begin
         spheres_tested <= 0;
         dist_limit <= longint'(HIT_LIMIT_RESET);
         fail_count <= 0;
         words_pending <= 0;
         hit_words.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_SPHERE_COUNT) begin
               spheres_tested <= int'(csr_bus.data[CNT_W-1:0]);
            end else if (csr_bus.index == CSR_HIT_LIMIT) begin
               dist_limit <= longint'(csr_bus.data[DIST_W-1:0]);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.kind == KIND_LOAD) begin
               center_tab[0][req_bus.slot] = longint'(req_bus.point_x);
               center_tab[1][req_bus.slot] = longint'(req_bus.point_y);
               center_tab[2][req_bus.slot] = longint'(req_bus.point_z);
               radius_tab[req_bus.slot] = longint'({1'b0, req_bus.radius});
               mat_tab[req_bus.slot] = req_bus.material_tag;
            end else begin
               o = '{longint'(req_bus.point_x), longint'(req_bus.point_y),
                     longint'(req_bus.point_z)};
               d = '{longint'(req_bus.dir_x), longint'(req_bus.dir_y),
                     longint'(req_bus.dir_z)};
               hit_words.push_back(nearest_hit(o, d));
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.hit, rsp_bus.distance, rsp_bus.hit_x, rsp_bus.hit_y,
                    rsp_bus.hit_z, rsp_bus.normal_x, rsp_bus.normal_y, rsp_bus.normal_z,
                    rsp_bus.material_out};
            if (hit_words.size() == 0) begin
               if (fail_count < 10) $display("Unexpected response word: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = hit_words.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("Response mismatch at %0t", $realtime);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         words_pending <= hit_words.size();
      end
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Top level of the ray/sphere regression. It loads the sphere table, programs the two
// registers in several settings (including the extremes), and fires ray words at the
// block, while the checker beside the block predicts and compares every response word.
module testbench;
   import rsnh_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam int     PHASES      = 8;
   localparam int     PHASE_WORDS = 115;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_pending;
   longint cycles = 0;

   // Sender and receiver pacing. When steady is set, neither side inserts gaps.
   bit steady;
   bit hold_rsp;

   // Shadow of the sphere centers, used only to aim rays at something.
   int aim_x [MAX_SPHERES];
   int aim_y [MAX_SPHERES];
   int aim_z [MAX_SPHERES];

   rsnh_req_if req_bus ();
   rsnh_rsp_if rsp_bus ();
   rsnh_csr_if csr_bus ();

   ray_sphere_nearest_hit_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rsnh_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: draws a pause before each response word. On request it also holds off
   // for a long stretch so that the block fills up and stalls its request side.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (hold_rsp) begin
            gap = 3000;
         end
         if (gap > 0) begin
            @(negedge clock) rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end
         @(negedge clock) rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Sends one request word after a random pause (none when steady is set) and returns once it has been taken.
   task automatic send_word(logic kind, logic [SLOT_W-1:0] slot, int px, int py, int pz,
                            int dx, int dy, int dz, logic [RAD_W-1:0] rad,
                            logic [MAT_W-1:0] mat);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.slot <= slot;
      req_bus.point_x <= px;
      req_bus.point_y <= py;
      req_bus.point_z <= pz;
      req_bus.dir_x <= dx;
      req_bus.dir_y <= dy;
      req_bus.dir_z <= dz;
      req_bus.radius <= rad;
      req_bus.material_tag <= mat;
      if (kind == KIND_LOAD) begin
         aim_x[slot] = px;
         aim_y[slot] = py;
         aim_z[slot] = pz;
      end
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic load_sphere(int slot, int cx, int cy, int cz, logic [RAD_W-1:0] rad,
                              logic [MAT_W-1:0] mat);
      send_word(KIND_LOAD, SLOT_W'(slot), cx, cy, cz, 0, 0, 0, rad, mat);
   endtask

   task automatic shoot_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      send_word(KIND_RAY, SLOT_W'($urandom), ox, oy, oz, dx, dy, dz, RAD_W'($urandom),
                MAT_W'($urandom));
   endtask

   // Lowers request valid, waits for every response word, then lets the last load settle.
   // Registers may only be written with the block idle.
   task automatic drain;
      @(negedge clock) req_bus.valid <= 1'b0;
      while (words_pending != 0 || (req_bus.valid && !req_bus.ready)) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock) csr_bus.valid <= 1'b0;
   endtask

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // A coordinate within +-64.0 in Q16.16.
   function automatic int scene_coord();
      return int'($urandom_range(0, 32'd8388608)) - 4194304;
   endfunction

   // A ray from a random point in the scene, mostly aimed at one of the spheres.
   task automatic aimed_ray;
      int     j;
      int     ox, oy, oz;
      longint ax, ay, az;
      int     sh;
      j = $urandom_range(0, MAX_SPHERES - 1);
      ox = scene_coord();
      oy = scene_coord();
      oz = scene_coord();
      sh = $urandom_range(0, 4);
      if ($urandom_range(0, 4) == 0) begin
         ax = scene_coord();
         ay = scene_coord();
         az = scene_coord();
      end else begin
         ax = ((longint'(aim_x[j]) - ox) >>> sh) + longint'($urandom_range(0, 8192)) - 4096;
         ay = ((longint'(aim_y[j]) - oy) >>> sh) + longint'($urandom_range(0, 8192)) - 4096;
         az = ((longint'(aim_z[j]) - oz) >>> sh) + longint'($urandom_range(0, 8192)) - 4096;
      end
      shoot_ray(ox, oy, oz, clip32(ax), clip32(ay), clip32(az));
   endtask

   initial begin
      int kind_draw;
      int cnt;
      logic [DIST_W-1:0] lim;
      steady = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_LOAD;
      req_bus.slot = '0;
      req_bus.point_x = 0;
      req_bus.point_y = 0;
      req_bus.point_z = 0;
      req_bus.dir_x = 0;
      req_bus.dir_y = 0;
      req_bus.dir_z = 0;
      req_bus.radius = '0;
      req_bus.material_tag = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_SPHERE_COUNT;
      csr_bus.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part. Slot 0 is a point sphere at the origin, so a ray starting there hits
      // at distance zero with the hit point on the center and a zero normal. Slot 15 sits
      // at the most negative x and most positive y, with the largest radius and material.
      for (int i = 0; i < MAX_SPHERES; i++) begin
         if (i == 0) begin
            load_sphere(0, 0, 0, 0, '0, 8'd0);
         end else if (i == MAX_SPHERES - 1) begin
            load_sphere(i, 32'sh80000000, 32'sh7FFFFFFF, 0, '1, 8'hFF);
         end else begin
            load_sphere(i, (i - 8) * 655360, i[0] ? 327680 : -327680, 2621440,
                        RAD_W'(196608 + i * 16384), MAT_W'(i * 17));
         end
      end
      // With the reset sphere count of zero nothing is tested, so this ray misses.
      shoot_ray(-4587520, 327680, 0, 0, 0, 65536);
      drain();
      write_csr(CSR_SPHERE_COUNT, 32'd16);
      write_csr(CSR_HIT_LIMIT, 32'(HIT_LIMIT_RESET));
      shoot_ray(0, 0, 0, 65536, 0, 0);
      shoot_ray(0, 0, 0, 0, 0, 65536);
      shoot_ray(-4587520, 327680, 0, 0, 0, 65536);
      shoot_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh80000000, 32'sh80000000);
      shoot_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      shoot_ray(655360, -327680, 0, 0, 0, 0);
      drain();
      // A zero limit turns every hit into a far hit.
      write_csr(CSR_HIT_LIMIT, 32'd0);
      shoot_ray(-4587520, 327680, 0, 0, 0, 65536);
      drain();
      // A count beyond the table size tests the whole table.
      write_csr(CSR_HIT_LIMIT, 32'h7FFFFFFF);
      write_csr(CSR_SPHERE_COUNT, 32'd31);
      shoot_ray(-4587520, 327680, 0, 0, 0, 65536);
      shoot_ray(0, 0, -65536, 0, 0, 32'sh7FFFFFFF);
      drain();

      // Random part, one register setting per phase.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cnt = 16;
            1: cnt = 1;
            3: cnt = 31;
            5: cnt = 0;
            default: cnt = $urandom_range(2, 16);
         endcase
         case (p)
            1: lim = '1;
            2: lim = HIT_LIMIT_RESET;
            4: lim = DIST_W'($urandom_range(0, 20 * 65536));
            6: lim = '0;
            default: lim = DIST_W'($urandom);
         endcase
         write_csr(CSR_SPHERE_COUNT, 32'(cnt));
         write_csr(CSR_HIT_LIMIT, 32'(lim));
         steady = (p == 3);
         hold_rsp = (p == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            kind_draw = $urandom_range(0, 99);
            if (kind_draw < 12) begin
               // Noise: every field drawn over its full range.
               send_word(1'($urandom), SLOT_W'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, RAD_W'($urandom), MAT_W'($urandom));
            end else if (kind_draw < 38) begin
               load_sphere($urandom_range(0, MAX_SPHERES - 1), scene_coord(), scene_coord(),
                           scene_coord(), RAD_W'($urandom_range(32768, 16 * 65536)),
                           MAT_W'($urandom));
            end else begin
               aimed_ray();
            end
         end
         drain();
      end

      steady = 1'b0;
      drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/rsnh_pkg.sv
src/rsnh_req_if.sv
src/rsnh_table.sv
src/rsnh_sqrt.sv
src/rsnh_div.sv
src/ray_sphere_nearest_hit_top.sv
test/rsnh_checker.sv
test/testbench.sv
